FILE: design/necirtx_pkg.sv
// ----------------------------------------------------------------------------
// necirtx_pkg: shared types and constants of the NEC infrared frame sender
// Transaction payloads, function codes, register indexes and frame constants.
// ----------------------------------------------------------------------------
package necirtx_pkg;

	// configuration port
	localparam int CFG_DATA_W = 14;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_LEAD_GAP     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_MARK  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_SPACE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE    = 3'd5;

	// register reset values in microsecond ticks
	localparam int RST_LEAD_GAP     = 1000;
	localparam int RST_HEADER_MARK  = 9000;
	localparam int RST_HEADER_SPACE = 4500;
	localparam int RST_BIT_MARK     = 562;
	localparam int RST_ZERO_SPACE   = 563;
	localparam int RST_ONE_SPACE    = 1688;

	// input function codes
	localparam logic FUNC_TICK  = 1'b0;
	localparam logic FUNC_START = 1'b1;

	// payload bits per frame
	localparam int                 BITS_LEFT_W = 6;
	localparam logic [BITS_LEFT_W-1:0] FRAME_BITS = 6'd32;

	typedef struct packed {
		logic       func;
		logic [7:0] address;
		logic [7:0] command;
	} in_item_t;

	typedef struct packed {
		logic carrier_enable;
		logic busy_res;
		logic frame_done;
	} out_item_t;

endpackage

FILE: design/necirtx_in_if.sv
// ----------------------------------------------------------------------------
// necirtx_in_if: input channel of the NEC frame sender
// Valid/ready handshake carrying tick and start transactions.
// ----------------------------------------------------------------------------
interface necirtx_in_if;
	import necirtx_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: design/necirtx_out_if.sv
// ----------------------------------------------------------------------------
// necirtx_out_if: result channel of the NEC frame sender
// Valid/ready handshake carrying one result transaction per input.
// ----------------------------------------------------------------------------
interface necirtx_out_if;
	import necirtx_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: design/nec_ir_frame_transmitter_top.sv
// ----------------------------------------------------------------------------
// nec_ir_frame_transmitter_top: NEC infrared frame sender
// The result of an accepted input transaction is registered and offered in the cycle after acceptance.
// Throughput: one transaction per cycle; an input is taken whenever the result
// register is empty or is drained in the same cycle, else it waits.
// Reset (arst_n low): idle phase, counters and frame word clear, registers
// back to their NEC defaults, no result pending.
// ----------------------------------------------------------------------------
module nec_ir_frame_transmitter_top #(
	parameter int TIMER_BITS = 14
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [necirtx_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [necirtx_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	necirtx_in_if.sink                           items,
	necirtx_out_if.source                        results
);
	import necirtx_pkg::*;

	// register writes keep at most the 14 data bits, then the timer width
	localparam int KEEP_W = (TIMER_BITS < CFG_DATA_W) ? TIMER_BITS : CFG_DATA_W;

	typedef logic [TIMER_BITS-1:0] ticks_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LEAD,
		PH_HMARK,
		PH_HSPACE,
		PH_BMARK,
		PH_BSPACE,
		PH_FMARK,
		PH_FSPACE
	} phase_t;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	ticks_t lead_gap_q, header_mark_q, header_space_q;
	ticks_t bit_mark_q, zero_space_q, one_space_q;
	ticks_t cfg_value;

	assign cfg_value = ticks_t'(cfg_wdata[KEEP_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_gap_q     <= ticks_t'(RST_LEAD_GAP);
			header_mark_q  <= ticks_t'(RST_HEADER_MARK);
			header_space_q <= ticks_t'(RST_HEADER_SPACE);
			bit_mark_q     <= ticks_t'(RST_BIT_MARK);
			zero_space_q   <= ticks_t'(RST_ZERO_SPACE);
			one_space_q    <= ticks_t'(RST_ONE_SPACE);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LEAD_GAP:     lead_gap_q     <= cfg_value;
				REG_HEADER_MARK:  header_mark_q  <= cfg_value;
				REG_HEADER_SPACE: header_space_q <= cfg_value;
				REG_BIT_MARK:     bit_mark_q     <= cfg_value;
				REG_ZERO_SPACE:   zero_space_q   <= cfg_value;
				REG_ONE_SPACE:    one_space_q    <= cfg_value;
				default: ;  // unmapped index, write dropped
			endcase
		end
	end

	// ------------------------------------------------------------------
	// frame state
	// ------------------------------------------------------------------
	phase_t                 phase_q, phase_n;
	logic [BITS_LEFT_W-1:0] bits_left_q, bits_left_n;
	ticks_t                 timer_q, timer_n;
	logic [31:0]            word_q, word_n;
	logic                   carrier_q, carrier_n;

	out_item_t res_n, res_q;
	logic      res_valid_q;
	logic      accept;

	// the result register frees up when empty or when it is being drained
	assign items.ready = !res_valid_q || results.ready;
	assign accept      = items.valid && items.ready;

	// next state and result of one transaction
	always_comb begin
		phase_n     = phase_q;
		bits_left_n = bits_left_q;
		timer_n     = timer_q;
		word_n      = word_q;
		carrier_n   = carrier_q;
		res_n       = '0;

		if (items.payload.func == FUNC_START) begin
			// a start while busy changes nothing
			if (phase_q == PH_IDLE) begin
				word_n      = {~items.payload.command, items.payload.command,
				               ~items.payload.address, items.payload.address};
				bits_left_n = FRAME_BITS;
				phase_n     = PH_LEAD;
				timer_n     = lead_gap_q;
				carrier_n   = 1'b0;
			end
			res_n.carrier_enable = (phase_q == PH_IDLE) ? 1'b0 : carrier_q;
			res_n.busy_res       = 1'b1;
		end else if (phase_q != PH_IDLE) begin
			res_n.carrier_enable = carrier_q;
			res_n.busy_res       = 1'b1;
			// a timer of zero counts as one tick
			if (timer_q > ticks_t'(1)) begin
				timer_n = timer_q - ticks_t'(1);
			end else begin
				unique case (phase_q)
					PH_LEAD: begin
						phase_n   = PH_HMARK;
						timer_n   = header_mark_q;
						carrier_n = 1'b1;
					end
					PH_HMARK: begin
						phase_n   = PH_HSPACE;
						timer_n   = header_space_q;
						carrier_n = 1'b0;
					end
					PH_HSPACE: begin
						phase_n   = PH_BMARK;
						timer_n   = bit_mark_q;
						carrier_n = 1'b1;
					end
					PH_BMARK: begin
						phase_n   = PH_BSPACE;
						timer_n   = word_q[0] ? one_space_q : zero_space_q;
						carrier_n = 1'b0;
					end
					PH_BSPACE: begin
						word_n    = {1'b0, word_q[31:1]};
						timer_n   = bit_mark_q;
						carrier_n = 1'b1;
						if (bits_left_q <= BITS_LEFT_W'(1)) begin
							bits_left_n = '0;
							phase_n     = PH_FMARK;
						end else begin
							bits_left_n = bits_left_q - BITS_LEFT_W'(1);
							phase_n     = PH_BMARK;
						end
					end
					PH_FMARK: begin
						phase_n   = PH_FSPACE;
						timer_n   = zero_space_q;
						carrier_n = 1'b0;
					end
					default: begin
						// end of the final space: frame complete
						phase_n            = PH_IDLE;
						timer_n            = '0;
						carrier_n          = 1'b0;
						res_n.frame_done   = 1'b1;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bits_left_q <= '0;
			timer_q     <= '0;
			word_q      <= '0;
			carrier_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q     <= phase_n;
				bits_left_q <= bits_left_n;
				timer_q     <= timer_n;
				word_q      <= word_n;
				carrier_q   <= carrier_n;
				res_valid_q <= 1'b1;
			end else if (results.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_n;
		end
	end

	assign results.valid   = res_valid_q;
	assign results.payload = res_q;

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: regression bench for the NEC infrared frame sender
// Drives tick and start transactions through the valid/ready channels, keeps
// its own tick-exact model of the frame timing and compares every result
// transaction against it. Covers idle ticks, zero and minimum segment
// lengths, ignored starts, and random traffic under several
// sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_top;
	import necirtx_pkg::*;

	// Bench-side model of the frame sequencer. Every accepted input
	// transaction yields exactly one expected result transaction.
	class nec_line_model;
		typedef enum logic [2:0] {
			SEG_IDLE, SEG_LEAD, SEG_HMARK, SEG_HSPACE,
			SEG_BMARK, SEG_BSPACE, SEG_FMARK, SEG_FSPACE
		} seg_t;

		logic [CFG_DATA_W-1:0] lead_gap, header_mark, header_space;
		logic [CFG_DATA_W-1:0] bit_mark, zero_space, one_space;

		seg_t                   seg;
		logic [BITS_LEFT_W-1:0] bits_left;
		logic [CFG_DATA_W-1:0]  seg_timer;
		logic [31:0]            frame_word;
		logic                   carrier;

		out_item_t expected_levels[$];
		int        mismatches;

		function new();
			lead_gap     = CFG_DATA_W'(RST_LEAD_GAP);
			header_mark  = CFG_DATA_W'(RST_HEADER_MARK);
			header_space = CFG_DATA_W'(RST_HEADER_SPACE);
			bit_mark     = CFG_DATA_W'(RST_BIT_MARK);
			zero_space   = CFG_DATA_W'(RST_ZERO_SPACE);
			one_space    = CFG_DATA_W'(RST_ONE_SPACE);
			seg          = SEG_IDLE;
			bits_left    = '0;
			seg_timer    = '0;
			frame_word   = '0;
			carrier      = 1'b0;
			mismatches   = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_LEAD_GAP:     lead_gap = val;
				REG_HEADER_MARK:  header_mark = val;
				REG_HEADER_SPACE: header_space = val;
				REG_BIT_MARK:     bit_mark = val;
				REG_ZERO_SPACE:   zero_space = val;
				REG_ONE_SPACE:    one_space = val;
				default: ;
			endcase
		endfunction

		function bit frame_active();
			return seg != SEG_IDLE;
		endfunction

		function bit pending();
			return expected_levels.size() != 0;
		endfunction

		function void open_segment(seg_t s, logic [CFG_DATA_W-1:0] len, logic car);
			seg       = s;
			seg_timer = len;
			carrier   = car;
		endfunction

		// moves on to the following segment, returns 1 when the frame is over
		function bit next_segment();
			case (seg)
				SEG_LEAD:   open_segment(SEG_HMARK, header_mark, 1'b1);
				SEG_HMARK:  open_segment(SEG_HSPACE, header_space, 1'b0);
				SEG_HSPACE: open_segment(SEG_BMARK, bit_mark, 1'b1);
				SEG_BMARK:  open_segment(SEG_BSPACE, frame_word[0] ? one_space : zero_space, 1'b0);
				SEG_BSPACE: begin
					frame_word = frame_word >> 1;
					if (bits_left <= 1) begin
						bits_left = '0;
						open_segment(SEG_FMARK, bit_mark, 1'b1);
					end else begin
						bits_left = bits_left - 1'b1;
						open_segment(SEG_BMARK, bit_mark, 1'b1);
					end
				end
				SEG_FMARK:  open_segment(SEG_FSPACE, zero_space, 1'b0);
				default: begin
					open_segment(SEG_IDLE, '0, 1'b0);
					return 1'b1;
				end
			endcase
			return 1'b0;
		endfunction

		function void take_item(in_item_t it);
			out_item_t lv;
			lv = '0;
			if (it.func == FUNC_START) begin
				// a start while busy is dropped but still answered
				if (seg == SEG_IDLE) begin
					frame_word = {~it.command, it.command, ~it.address, it.address};
					bits_left  = FRAME_BITS;
					open_segment(SEG_LEAD, lead_gap, 1'b0);
				end
				lv.carrier_enable = carrier;
				lv.busy_res       = 1'b1;
			end else if (seg != SEG_IDLE) begin
				lv.carrier_enable = carrier;
				lv.busy_res       = 1'b1;
				// zero-length segments behave as one tick
				if (seg_timer > 1)
					seg_timer = seg_timer - 1'b1;
				else
					lv.frame_done = next_segment();
			end
			expected_levels.push_back(lv);
		endfunction

		task report_mismatch(string what);
			$display("MISMATCH: %s", what);
			mismatches++;
		endtask

		task match_levels(out_item_t got);
			out_item_t exp;
			if (expected_levels.size() == 0) begin
				report_mismatch($sformatf("unexpected result %b", got));
				return;
			end
			exp = expected_levels.pop_front();
			if (got.carrier_enable !== exp.carrier_enable)
				report_mismatch($sformatf("carrier_enable %b, expected %b",
					got.carrier_enable, exp.carrier_enable));
			if (got.busy_res !== exp.busy_res)
				report_mismatch($sformatf("busy_res %b, expected %b",
					got.busy_res, exp.busy_res));
			if (got.frame_done !== exp.frame_done)
				report_mismatch($sformatf("frame_done %b, expected %b",
					got.frame_done, exp.frame_done));
		endtask
	endclass

	// generous bound on the length of the whole run
	localparam int CYCLE_LIMIT = 100000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	necirtx_in_if  items_if();
	necirtx_out_if results_if();

	nec_line_model model = new();

	int idle_pct;     // chance in percent that the sender holds off a cycle
	int stall_pct;    // chance in percent that the receiver drops ready
	int cycle_count = 0;

	nec_ir_frame_transmitter_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.items     (items_if),
		.results   (results_if)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Receiver side: ready is redrawn every cycle from the current stall rate.
	always @(posedge clk)
		results_if.ready <= ($urandom_range(99) >= stall_pct);

	// Result monitor. Sampled at the edge, before any nonblocking update, so
	// the handshake seen here is the one that actually took place.
	always @(posedge clk)
		if (arst_n && results_if.valid && results_if.ready)
			model.match_levels(results_if.payload);

	// Watchdog: a hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic in_item_t make_item(logic func, logic [7:0] addr, logic [7:0] cmd);
		in_item_t it;
		it.func    = func;
		it.address = addr;
		it.command = cmd;
		return it;
	endfunction

	// Mostly tiny segment lengths keep frames short; zero is a legal corner.
	function automatic logic [CFG_DATA_W-1:0] rand_ticks();
		int r;
		r = $urandom_range(99);
		if (r < 15)
			return '0;
		else if (r < 90)
			return CFG_DATA_W'($urandom_range(2, 1));
		return CFG_DATA_W'($urandom_range(6, 3));
	endfunction

	// One input transaction. valid stays high after acceptance so that a
	// following call can chain without a bubble; it only drops on idle cycles.
	task automatic send_item(input in_item_t it);
		while ($urandom_range(99) < idle_pct) begin
			items_if.valid <= 1'b0;
			@(posedge clk);
		end
		items_if.valid   <= 1'b1;
		items_if.payload <= it;
		do @(posedge clk); while (!items_if.ready);
		model.take_item(it);
	endtask

	task automatic send_ticks(input int n);
		repeat (n)
			send_item(make_item(FUNC_TICK, 8'($urandom_range(255)),
				8'($urandom_range(255))));
	endtask

	// Tick until the model says the frame has closed.
	task automatic finish_frame();
		while (model.frame_active())
			send_item(make_item(FUNC_TICK, 8'($urandom_range(255)),
				8'($urandom_range(255))));
	endtask

	// Sender goes quiet until every expected result transaction has arrived.
	task automatic wait_quiet();
		items_if.valid <= 1'b0;
		do @(posedge clk); while (model.pending());
		repeat (2) @(posedge clk);
	endtask

	// Back-to-back register writes; we stays high across the burst.
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		model.set_reg(idx, val);
	endtask

	// Only called with no frame running and no transaction in flight.
	task automatic program_timing(input logic [CFG_DATA_W-1:0] lead, hmark, hspace,
			bmark, zspace, ospace);
		cfg_write(REG_LEAD_GAP, lead);
		cfg_write(REG_HEADER_MARK, hmark);
		cfg_write(REG_HEADER_SPACE, hspace);
		cfg_write(REG_BIT_MARK, bmark);
		cfg_write(REG_ZERO_SPACE, zspace);
		cfg_write(REG_ONE_SPACE, ospace);
		cfg_we <= 1'b0;
	endtask

	initial begin
		in_item_t it;

		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = '0;
		cfg_wdata          = '0;
		items_if.valid     = 1'b0;
		items_if.payload   = '0;
		idle_pct           = 0;
		stall_pct          = 0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part, full rate on both sides ---

		// ticks while idle report all zero, whatever the bytes
		send_item(make_item(FUNC_TICK, 8'hFF, 8'hFF));
		send_item(make_item(FUNC_TICK, 8'h00, 8'h00));
		wait_quiet();

		// zero lengths act as one tick; starts mid-frame are dropped;
		// a new start right on the heels of done
		program_timing('0, '0, '0, '0, '0, '0);
		send_item(make_item(FUNC_START, 8'h00, 8'hFF));
		send_item(make_item(FUNC_START, 8'h5A, 8'hA5));   // dropped, carrier off
		send_ticks(1);                                      // now inside the header mark
		send_item(make_item(FUNC_START, 8'h3C, 8'hC3));   // dropped, carrier on
		finish_frame();
		send_item(make_item(FUNC_START, 8'h81, 8'h7E));
		finish_frame();
		wait_quiet();

		// shortest explicit lengths
		program_timing(14'd1, 14'd1, 14'd1, 14'd1, 14'd1, 14'd1);
		send_item(make_item(FUNC_START, 8'hA5, 8'h3C));
		finish_frame();
		wait_quiet();

		// --- random part: one timing set per idling mix ---
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 70; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 70; end
				default: begin idle_pct = 12; stall_pct = 12; end
			endcase
			program_timing(rand_ticks(), rand_ticks(), rand_ticks(),
				rand_ticks(), rand_ticks(), rand_ticks());

			for (int n = 0; n < 100; n++) begin
				// mostly well-formed frames: start when idle, then ticks;
				// idle ticks and starts during a frame are the noise
				it = make_item(FUNC_TICK, 8'($urandom_range(255)),
					8'($urandom_range(255)));
				if (!model.frame_active())
					it.func = ($urandom_range(99) < 60) ? FUNC_START : FUNC_TICK;
				else
					it.func = ($urandom_range(99) < 4) ? FUNC_START : FUNC_TICK;
				send_item(it);
				// sender holds off mid-stream until the pipe has emptied
				if (n == 50)
					wait_quiet();
			end
			finish_frame();
			wait_quiet();
		end

		repeat (8) @(posedge clk);
		if (model.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
